/* design/atc_pkg.sv */
// ----------------------------------------------------------------------------
// atc_pkg
// Shared types and codes for the affine transform composer.
// ----------------------------------------------------------------------------
package atc_pkg;

   localparam logic [2:0] CMD_IDENTITY  = 3'd0;
   localparam logic [2:0] CMD_TRANSLATE = 3'd1;
   localparam logic [2:0] CMD_SCALE     = 3'd2;
   localparam logic [2:0] CMD_ROTATE    = 3'd3;
   localparam logic [2:0] CMD_MIRROR    = 3'd4;
   localparam logic [2:0] CMD_BUFFER    = 3'd5;

   localparam logic [2:0] BUF_NORMAL     = 3'd0;
   localparam logic [2:0] BUF_CCW90      = 3'd1;
   localparam logic [2:0] BUF_CCW180     = 3'd2;
   localparam logic [2:0] BUF_CCW270     = 3'd3;
   localparam logic [2:0] BUF_FLIPPED    = 3'd4;
   localparam logic [2:0] BUF_FLIPPED90  = 3'd5;
   localparam logic [2:0] BUF_FLIPPED180 = 3'd6;
   localparam logic [2:0] BUF_FLIPPED270 = 3'd7;

   // elementary matrix kinds applied by the datapath
   localparam logic [1:0] EL_TRANSLATE = 2'd0;
   localparam logic [1:0] EL_SCALE     = 2'd1;
   localparam logic [1:0] EL_ROTATE    = 2'd2;
   localparam logic [1:0] EL_MIRROR    = 2'd3;

   typedef struct packed {
      logic [2:0]         cmd;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
      logic [1:0]         quarter_turns;
      logic [2:0]         buffer_code;
   } req_type;

   typedef struct packed {
      logic signed [31:0] m00;
      logic signed [31:0] m01;
      logic signed [31:0] m02;
      logic signed [31:0] m10;
      logic signed [31:0] m11;
      logic signed [31:0] m12;
      logic signed [31:0] m20;
      logic signed [31:0] m21;
      logic signed [31:0] m22;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic               load_id;
      logic               start;
      logic [1:0]         kind;
      logic signed [31:0] p;
      logic signed [31:0] q;
      logic [1:0]         turns;
   } cmd_type;

   typedef struct packed {
      logic busy;
   } status_type;

   function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
      logic signed [31:0] r;
      if (v == 32'sh8000_0000) r = 32'sh7fff_ffff;
      else                     r = -v;
      return r;
   endfunction

endpackage

/* design/atc_datapath.sv */
// ----------------------------------------------------------------------------
// atc_datapath
// Matrix register file and one shared multiplier; M <- M * E, one term a cycle.
// ----------------------------------------------------------------------------
module atc_datapath #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  atc_pkg::cmd_type     ctl,
   output atc_pkg::status_type  sts,
   output atc_pkg::rsp_type     mat
);

   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

   logic signed [31:0] m_ff [9];
   logic signed [31:0] r_ff [9];
   logic signed [31:0] m_in [9];
   logic signed [31:0] r_in [9];
   logic               busy_ff, busy_in;
   logic [1:0]         kind_ff, kind_in, turns_ff, turns_in;
   logic signed [31:0] p_ff, p_in, q_ff, q_in;
   logic [1:0]         i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic signed [63:0] prod_ff, prod_in;
   logic               pv_ff, pv_in, plast_ff, plast_in;
   logic [3:0]         pidx_ff, pidx_in;
   logic signed [63:0] acc_ff, acc_in;

   logic signed [31:0] e_val, cs, sn, mop;
   logic signed [63:0] term, sum;
   logic [3:0]         widx;

   // element E[k][j] of the current elementary matrix
   always_comb begin
      cs = '0;
      sn = '0;
      case (turns_ff)
         2'd0:    cs = ONE;
         2'd1:    sn = ONE;
         2'd2:    cs = -ONE;
         default: sn = -ONE;
      endcase
      e_val = (k_ff == j_ff) ? ONE : '0;
      case (kind_ff)
         atc_pkg::EL_TRANSLATE: begin
            if (k_ff == 2'd0 && j_ff == 2'd2) e_val = p_ff;
            if (k_ff == 2'd1 && j_ff == 2'd2) e_val = q_ff;
         end
         atc_pkg::EL_SCALE: begin
            if (k_ff == 2'd0 && j_ff == 2'd0) e_val = p_ff;
            if (k_ff == 2'd1 && j_ff == 2'd1) e_val = q_ff;
         end
         atc_pkg::EL_ROTATE: begin
            if (k_ff == 2'd0 && j_ff == 2'd0) e_val = cs;
            if (k_ff == 2'd0 && j_ff == 2'd1) e_val = -sn;
            if (k_ff == 2'd1 && j_ff == 2'd0) e_val = sn;
            if (k_ff == 2'd1 && j_ff == 2'd1) e_val = cs;
         end
         default: begin
            if (k_ff == 2'd0 && j_ff == 2'd0) e_val = -ONE;
            if (k_ff == 2'd0 && j_ff == 2'd2) e_val = p_ff;
         end
      endcase
      mop = m_ff[4'(i_ff) * 4'd3 + 4'(k_ff)];
   end

   assign term = prod_ff >>> FRAC_BITS;
   assign sum  = acc_ff + term;

   always_comb begin
      busy_in  = busy_ff;
      kind_in  = kind_ff;
      turns_in = turns_ff;
      p_in     = p_ff;
      q_in     = q_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      m_in     = m_ff;
      r_in     = r_ff;
      pv_in    = 1'b0;
      plast_in = 1'b0;
      pidx_in  = pidx_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      widx     = pidx_ff;
      if (ctl.load_id) begin
         for (int n = 0; n < 9; n++) m_in[n] = (n % 4 == 0) ? ONE : '0;
      end
      if (ctl.start) begin
         busy_in  = 1'b1;
         kind_in  = ctl.kind;
         turns_in = ctl.turns;
         p_in     = ctl.p;
         q_in     = ctl.q;
         i_in     = '0;
         j_in     = '0;
         k_in     = '0;
      end else if (busy_ff && i_ff != 2'd3) begin
         // issue one product per cycle
         prod_in  = 64'(mop) * 64'(e_val);
         pv_in    = 1'b1;
         plast_in = (k_ff == 2'd2);
         pidx_in  = 4'(i_ff) * 4'd3 + 4'(j_ff);
         if (k_ff == 2'd2) begin
            k_in = '0;
            if (j_ff == 2'd2) begin
               j_in = '0;
               i_in = i_ff + 2'd1;
            end else begin
               j_in = j_ff + 2'd1;
            end
         end else begin
            k_in = k_ff + 2'd1;
         end
      end
      if (pv_ff) begin
         if (plast_ff) begin
            acc_in = '0;
            if (sum > 64'sh0000_0000_7fff_ffff)      r_in[widx] = 32'sh7fff_ffff;
            else if (sum < 64'shffff_ffff_8000_0000) r_in[widx] = 32'sh8000_0000;
            else                                     r_in[widx] = sum[31:0];
            if (widx == 4'd8) begin
               busy_in = 1'b0;
               m_in    = r_in;
            end
         end else begin
            acc_in = sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pv_ff   <= 1'b0;
         acc_ff  <= '0;
         i_ff    <= '0;
         j_ff    <= '0;
         k_ff    <= '0;
         for (int n = 0; n < 9; n++) m_ff[n] <= (n % 4 == 0) ? ONE : '0;
      end else begin
         busy_ff <= busy_in;
         pv_ff   <= pv_in;
         acc_ff  <= acc_in;
         i_ff    <= i_in;
         j_ff    <= j_in;
         k_ff    <= k_in;
         m_ff    <= m_in;
      end
      kind_ff  <= kind_in;
      turns_ff <= turns_in;
      p_ff     <= p_in;
      q_ff     <= q_in;
      r_ff     <= r_in;
      prod_ff  <= prod_in;
      plast_ff <= plast_in;
      pidx_ff  <= pidx_in;
   end

   assign sts.busy = busy_ff;
   assign mat = '{m00: m_ff[0], m01: m_ff[1], m02: m_ff[2],
                  m10: m_ff[3], m11: m_ff[4], m12: m_ff[5],
                  m20: m_ff[6], m21: m_ff[7], m22: m_ff[8]};

endmodule

/* design/atc_controller.sv */
// ----------------------------------------------------------------------------
// atc_controller
// Breaks each command into a short list of elementary products.
// ----------------------------------------------------------------------------
module atc_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  atc_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 snap,
   output atc_pkg::cmd_type     ctl,
   input  atc_pkg::status_type  sts
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [2:0]         step_ff, step_in;
   logic               rv_ff, rv_in;
   atc_pkg::req_type   r_ff, r_in;

   logic               accept, last;
   logic signed [31:0] a, b, hw, hh, nw, nh;

   assign a  = r_ff.operand_a;
   assign b  = r_ff.operand_b;
   assign hw = a >>> 1;
   assign hh = b >>> 1;
   assign nw = atc_pkg::neg_sat(a);
   assign nh = atc_pkg::neg_sat(b);

   assign req_stall = (state_ff != ST_IDLE) || (rv_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rv_ff;

   // step list for the held command
   always_comb begin
      ctl.load_id = 1'b0;
      ctl.start   = 1'b0;
      ctl.kind    = atc_pkg::EL_TRANSLATE;
      ctl.p       = '0;
      ctl.q       = '0;
      ctl.turns   = '0;
      last        = 1'b1;
      case (r_ff.cmd)
         atc_pkg::CMD_TRANSLATE: begin
            ctl.p = a;
            ctl.q = b;
         end
         atc_pkg::CMD_SCALE: begin
            ctl.kind = atc_pkg::EL_SCALE;
            ctl.p    = a;
            ctl.q    = b;
         end
         atc_pkg::CMD_ROTATE: begin
            last = (step_ff == 3'd2);
            case (step_ff)
               3'd0: begin ctl.p = a; ctl.q = b; end
               3'd1: begin ctl.kind = atc_pkg::EL_ROTATE; ctl.turns = r_ff.quarter_turns; end
               default: begin ctl.p = nw; ctl.q = nh; end
            endcase
         end
         atc_pkg::CMD_MIRROR: begin
            ctl.kind = atc_pkg::EL_MIRROR;
            ctl.p    = a;
         end
         default: begin
            case (r_ff.buffer_code)
               atc_pkg::BUF_CCW90, atc_pkg::BUF_FLIPPED90,
               atc_pkg::BUF_CCW270, atc_pkg::BUF_FLIPPED270: begin
                  last = r_ff.buffer_code[2] ? (step_ff == 3'd2) : (step_ff == 3'd1);
                  case (step_ff)
                     3'd0: begin
                        ctl.kind  = atc_pkg::EL_ROTATE;
                        ctl.turns = r_ff.buffer_code[1] ? 2'd1 : 2'd3;
                     end
                     3'd1: begin
                        if (r_ff.buffer_code[1]) ctl.q = nw;
                        else                     ctl.p = nh;
                     end
                     default: begin
                        ctl.kind = atc_pkg::EL_MIRROR;
                        ctl.p    = b;
                     end
                  endcase
               end
               atc_pkg::BUF_CCW180, atc_pkg::BUF_FLIPPED180: begin
                  last = r_ff.buffer_code[2] ? (step_ff == 3'd3) : (step_ff == 3'd2);
                  case (step_ff)
                     3'd0: begin ctl.p = hw; ctl.q = hh; end
                     3'd1: begin ctl.kind = atc_pkg::EL_ROTATE; ctl.turns = 2'd2; end
                     3'd2: begin
                        ctl.p = atc_pkg::neg_sat(hw);
                        ctl.q = atc_pkg::neg_sat(hh);
                     end
                     default: begin ctl.kind = atc_pkg::EL_MIRROR; ctl.p = a; end
                  endcase
               end
               default: begin
                  ctl.kind = atc_pkg::EL_MIRROR;
                  ctl.p    = a;
               end
            endcase
         end
      endcase
      if (state_ff == ST_ISSUE) ctl.start = 1'b1;
      if (accept && req_data.cmd == atc_pkg::CMD_IDENTITY) ctl.load_id = 1'b1;
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      r_in     = r_ff;
      rv_in    = rv_ff && rsp_stall;
      snap     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               r_in    = req_data;
               step_in = '0;
               if (req_data.cmd == atc_pkg::CMD_TRANSLATE || req_data.cmd == atc_pkg::CMD_SCALE
                   || req_data.cmd == atc_pkg::CMD_ROTATE || req_data.cmd == atc_pkg::CMD_MIRROR
                   || (req_data.cmd == atc_pkg::CMD_BUFFER
                       && req_data.buffer_code != atc_pkg::BUF_NORMAL))
                  state_in = ST_ISSUE;
               else
                  state_in = ST_DONE;
            end
         end
         ST_ISSUE: state_in = ST_WAIT;
         ST_WAIT: begin
            if (!sts.busy) begin
               if (last) begin
                  state_in = ST_DONE;
               end else begin
                  step_in  = step_ff + 3'd1;
                  state_in = ST_ISSUE;
               end
            end
         end
         default: begin
            // matrix settled: capture it as the output beat
            snap     = 1'b1;
            rv_in    = 1'b1;
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         step_ff  <= step_in;
      end
      r_ff <= r_in;
   end

endmodule

/* design/affine_transform_composer.sv */
// An identity or no-op beat goes straight from idle to the done state; any other
// beat first runs its elementary products one after another. Each product is a
// start, 27 terms through one shared multiplier, a final accumulate and a status
// check; up to four products. No new beat is taken until the last one is done,
// and a stalled result holds off the next beat. Synchronous reset sets identity
// and clears handshake state.
// ----------------------------------------------------------------------------
// affine_transform_composer
// Composes a 3x3 Q16.16 transform from elementary commands.
// ----------------------------------------------------------------------------
module affine_transform_composer #(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  atc_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output atc_pkg::rsp_type  rsp_data
);

   atc_pkg::cmd_type    ctl;
   atc_pkg::status_type sts;
   atc_pkg::rsp_type    mat;
   atc_pkg::rsp_type    out_ff;
   logic                snap;

   atc_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .sts   (sts),
      .mat   (mat)
   );

   atc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .snap      (snap),
      .ctl       (ctl),
      .sts       (sts)
   );

   always_ff @(posedge clock) begin
      if (snap) out_ff <= mat;
   end

   assign rsp_data = out_ff;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the affine transform composer: a directed table
// and random command chains, each response checked against a local model.
// ----------------------------------------------------------------------------
module tb;

   localparam int FRAC = 16;
   localparam logic signed [31:0] ONE = 32'sh0001_0000;
   localparam logic signed [31:0] SMAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] SMIN = 32'sh8000_0000;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef logic signed [31:0] mat_type [9];

   typedef struct {
      atc_pkg::req_type req;
      bit               has_fixed;
      atc_pkg::rsp_type fixed;
   } dir_row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   atc_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   atc_pkg::rsp_type rsp_data;

   mat_type          model_mat;
   atc_pkg::rsp_type matrix_q[$];
   int               mismatch_count;
   int               beats_in;
   int               beats_out;
   int               idle_cycles;
   bit               stim_done;

   affine_transform_composer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------ fixed point
   function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sh0000_0000_7fff_ffff) return SMAX;
      if (v < -64'sh0000_0000_8000_0000) return SMIN;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] negate_clamped(input logic signed [31:0] v);
      return clamp32(-64'(v));
   endfunction

   function automatic void set_ident(ref mat_type e);
      foreach (e[i]) e[i] = 0;
      e[0] = ONE;
      e[4] = ONE;
      e[8] = ONE;
   endfunction

   function automatic void mat_mul(ref mat_type m, input mat_type e);
      mat_type r;
      logic signed [63:0] acc;
      logic signed [63:0] prod;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) begin
               prod = 64'(m[i*3+k]) * 64'(e[k*3+j]);
               acc += (prod >>> FRAC);
            end
            r[i*3+j] = clamp32(acc);
         end
      end
      m = r;
   endfunction

   function automatic void apply_translate(ref mat_type m, input logic signed [31:0] tx,
                                           input logic signed [31:0] ty);
      mat_type e;
      set_ident(e);
      e[2] = tx;
      e[5] = ty;
      mat_mul(m, e);
   endfunction

   function automatic void apply_rotate(ref mat_type m, input logic [1:0] qt,
                                        input logic signed [31:0] px,
                                        input logic signed [31:0] py);
      mat_type e;
      logic signed [31:0] c, s;
      case (qt)
         2'd0: begin c = ONE;  s = 0;    end
         2'd1: begin c = 0;    s = ONE;  end
         2'd2: begin c = -ONE; s = 0;    end
         default: begin c = 0; s = -ONE; end
      endcase
      apply_translate(m, px, py);
      set_ident(e);
      e[0] = c;
      e[1] = -s;
      e[3] = s;
      e[4] = c;
      mat_mul(m, e);
      apply_translate(m, negate_clamped(px), negate_clamped(py));
   endfunction

   function automatic void apply_mirror(ref mat_type m, input logic signed [31:0] w);
      mat_type e;
      set_ident(e);
      e[0] = -ONE;
      e[2] = w;
      mat_mul(m, e);
   endfunction

   function automatic void apply_buffer(ref mat_type m, input logic [2:0] code,
                                        input logic signed [31:0] w,
                                        input logic signed [31:0] h);
      case (code)
         atc_pkg::BUF_CCW90, atc_pkg::BUF_FLIPPED90: begin
            apply_rotate(m, 2'd3, 0, 0);
            apply_translate(m, negate_clamped(h), 0);
         end
         atc_pkg::BUF_CCW180, atc_pkg::BUF_FLIPPED180:
            apply_rotate(m, 2'd2, w >>> 1, h >>> 1);
         atc_pkg::BUF_CCW270, atc_pkg::BUF_FLIPPED270: begin
            apply_rotate(m, 2'd1, 0, 0);
            apply_translate(m, 0, negate_clamped(w));
         end
         default: ;
      endcase
      case (code)
         atc_pkg::BUF_FLIPPED, atc_pkg::BUF_FLIPPED180: apply_mirror(m, w);
         atc_pkg::BUF_FLIPPED90, atc_pkg::BUF_FLIPPED270: apply_mirror(m, h);
         default: ;
      endcase
   endfunction

   // advances the model matrix by one command and returns the new matrix
   function automatic atc_pkg::rsp_type compose_next(input atc_pkg::req_type r);
      mat_type e;
      atc_pkg::rsp_type o;
      case (r.cmd)
         atc_pkg::CMD_IDENTITY:  set_ident(model_mat);
         atc_pkg::CMD_TRANSLATE: apply_translate(model_mat, r.operand_a, r.operand_b);
         atc_pkg::CMD_SCALE: begin
            set_ident(e);
            e[0] = r.operand_a;
            e[4] = r.operand_b;
            mat_mul(model_mat, e);
         end
         atc_pkg::CMD_ROTATE:
            apply_rotate(model_mat, r.quarter_turns, r.operand_a, r.operand_b);
         atc_pkg::CMD_MIRROR: apply_mirror(model_mat, r.operand_a);
         atc_pkg::CMD_BUFFER:
            apply_buffer(model_mat, r.buffer_code, r.operand_a, r.operand_b);
         default: ;
      endcase
      o = '{model_mat[0], model_mat[1], model_mat[2], model_mat[3], model_mat[4],
            model_mat[5], model_mat[6], model_mat[7], model_mat[8]};
      return o;
   endfunction

   // ---------------------------------------------------------------- stimulus
   function automatic atc_pkg::req_type mk(input logic [2:0] c,
                                           input logic signed [31:0] a,
                                           input logic signed [31:0] b,
                                           input logic [1:0] qt,
                                           input logic [2:0] bc);
      atc_pkg::req_type r;
      r.cmd = c;
      r.operand_a = a;
      r.operand_b = b;
      r.quarter_turns = qt;
      r.buffer_code = bc;
      return r;
   endfunction

   function automatic logic signed [31:0] rand_operand();
      case ($urandom_range(0, 9))
         0: return SMAX;
         1: return SMIN;
         2: return $urandom();
         3, 4: return 32'($urandom_range(0, 8)) << FRAC;
         5: return -(32'($urandom_range(0, 8)) << FRAC);
         default: return 32'(signed'($urandom_range(0, 32'h0006_0000))) - 32'sh0003_0000;
      endcase
   endfunction

   function automatic atc_pkg::req_type rand_req();
      atc_pkg::req_type r;
      r = mk(3'($urandom_range(0, 7)), rand_operand(), rand_operand(),
             2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
      // identity mostly keeps the matrix from saturating into a fixed point
      if (r.cmd == 3'd7 && $urandom_range(0, 1)) r.cmd = atc_pkg::CMD_IDENTITY;
      return r;
   endfunction

   function automatic int gap_len();
      if ($urandom_range(0, 99) < 40) return 0;
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_beat(input atc_pkg::req_type r);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      matrix_q.push_back(compose_next(r));
      beats_in++;
   endtask

   dir_row_type dir_rows[$];

   task automatic build_table();
      atc_pkg::rsp_type id_m;
      atc_pkg::rsp_type sat_m;
      id_m  = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
      sat_m = '{SMAX, 0, 0, 0, SMAX, 0, 0, 0, ONE};
      dir_rows.push_back('{mk(3'd6, SMAX, SMIN, 2'd3, 3'd7), 1, id_m});
      dir_rows.push_back('{mk(atc_pkg::CMD_IDENTITY, SMIN, SMAX, 2'd0, 3'd0), 1, id_m});
      dir_rows.push_back('{mk(atc_pkg::CMD_TRANSLATE, SMAX, SMIN, 2'd0, 3'd0), 1,
                           '{ONE, 0, SMAX, 0, ONE, SMIN, 0, 0, ONE}});
      dir_rows.push_back('{mk(atc_pkg::CMD_IDENTITY, 0, 0, 2'd0, 3'd0), 1, id_m});
      dir_rows.push_back('{mk(atc_pkg::CMD_SCALE, SMAX, SMAX, 2'd0, 3'd0), 1, sat_m});
      dir_rows.push_back('{mk(atc_pkg::CMD_SCALE, SMAX, SMAX, 2'd0, 3'd0), 1, sat_m});
      dir_rows.push_back('{mk(atc_pkg::CMD_IDENTITY, 0, 0, 2'd0, 3'd0), 1, id_m});
      dir_rows.push_back('{mk(atc_pkg::CMD_SCALE, SMIN, 32'sh0002_0000, 2'd0, 3'd0), 0,
                           id_m});
      dir_rows.push_back('{mk(3'd7, 0, 0, 2'd0, 3'd0), 0, id_m});
      dir_rows.push_back('{mk(atc_pkg::CMD_IDENTITY, 0, 0, 2'd0, 3'd0), 1, id_m});
      for (int qt = 0; qt < 4; qt++)
         dir_rows.push_back('{mk(atc_pkg::CMD_ROTATE, 32'sh0003_0000, SMIN, 2'(qt), 3'd0),
                              0, id_m});
      dir_rows.push_back('{mk(atc_pkg::CMD_MIRROR, SMIN, 0, 2'd0, 3'd0), 0, id_m});
      dir_rows.push_back('{mk(atc_pkg::CMD_IDENTITY, 0, 0, 2'd0, 3'd0), 1, id_m});
      for (int bc = 0; bc < 8; bc++)
         dir_rows.push_back('{mk(atc_pkg::CMD_BUFFER, -32'sh0000_0003 + bc,
                                 32'sh0140_0000 + bc, 2'd0, 3'(bc)), 0, id_m});
   endtask

   initial begin
      atc_pkg::req_type r;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      stim_done = 1'b0;
      set_ident(model_mat);
      build_table();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_rows[n]) begin
         send_beat(dir_rows[n].req);
         // typed-in expectation must agree with the model for the row
         if (dir_rows[n].has_fixed && matrix_q[$] != dir_rows[n].fixed) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("table row %0d: typed %h model %h", n, dir_rows[n].fixed,
                        matrix_q[$]);
         end
      end
      for (int n = 0; n < 400; n++) begin
         r = rand_req();
         send_beat(r);
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // ---------------------------------------------------------------- response
   initial begin
      rsp_stall = 1'b1;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 99) < 3) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(10, 60)) @(posedge clock);
         end else if ($urandom_range(0, 99) < 30) begin
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      atc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_out++;
         if (matrix_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected matrix beat %h", rsp_data);
         end else begin
            want = matrix_q.pop_front();
            if (rsp_data != want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("matrix beat %0d mismatch", beats_out);
                  $display("  exp %h %h %h | %h %h %h | %h %h %h", want.m00, want.m01,
                           want.m02, want.m10, want.m11, want.m12, want.m20, want.m21,
                           want.m22);
                  $display("  got %h %h %h | %h %h %h | %h %h %h", rsp_data.m00,
                           rsp_data.m01, rsp_data.m02, rsp_data.m10, rsp_data.m11,
                           rsp_data.m12, rsp_data.m20, rsp_data.m21, rsp_data.m22);
               end
            end
         end
      end
   end

   // watchdog: cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      mismatch_count = 0;
      beats_in = 0;
      beats_out = 0;
      fork
         begin
            wait (stim_done && matrix_q.size() == 0);
            repeat (80) @(posedge clock);
         end
         begin
            wait (idle_cycles >= WATCHDOG_LIMIT);
            $display("watchdog expired with %0d matrices outstanding", matrix_q.size());
            $display("Regression FAIL");
            $finish;
         end
      join_any
      $display("%0d commands sent, %0d matrices checked, all commands and buffer codes",
               beats_in, beats_out);
      if (mismatch_count == 0 && matrix_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
